/* src/rna_pkg.sv */
// ----------------------------------------------------------------------------
// rna_pkg
// Shared types and codes for the rational number ALU and its iterative unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rna_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned CntW  = 7;
  localparam int unsigned ShW   = 6;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_CMP  = 3'd4,
    CMD_INC  = 3'd5,
    CMD_DEC  = 3'd6,
    CMD_PASS = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    UOP_MUL = 2'd0,
    UOP_DIV = 2'd1,
    UOP_GCD = 2'd2
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } rna_ctl_t;

endpackage

`default_nettype wire

/* src/rna_unit.sv */
// ----------------------------------------------------------------------------
// rna_unit
// Shared iterative unit: shift-add multiply (32 x 32), restoring divide
// (64 / 64, one quotient bit per cycle) and binary gcd, all on one adder.
// ----------------------------------------------------------------------------
`default_nettype none

module rna_unit import rna_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rna_ctl_t         ctl_i,
  input  wire logic [WordW-1:0] x_i,
  input  wire logic [WordW-1:0] y_i,
  output logic                  done_o,
  output logic [WordW-1:0]      res_o
);

  unit_op_e         op_q;
  logic             busy_q;
  logic             done_q;
  logic [WordW-1:0] r0_q, r1_q, r2_q;
  logic [CntW-1:0]  cnt_q;
  logic [ShW-1:0]   k_q;

  logic [WordW+1:0] op_a, op_b, sum;
  logic             sub;
  logic             borrow;
  logic [WordW:0]   rem_sh;

  assign rem_sh = {r2_q, r0_q[WordW-1]};

  always_comb begin
    op_a = '0;
    op_b = '0;
    sub  = 1'b0;
    case (op_q)
      UOP_MUL: begin
        op_a = {2'b00, r0_q};
        op_b = {2'b00, r1_q};
      end
      UOP_DIV: begin
        op_a = {1'b0, rem_sh};
        op_b = {2'b00, r1_q};
        sub  = 1'b1;
      end
      default: begin
        op_a = {2'b00, r0_q};
        op_b = {2'b00, r1_q};
        sub  = 1'b1;
      end
    endcase
    sum    = sub ? (op_a - op_b) : (op_a + op_b);
    borrow = sum[WordW+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= UOP_MUL;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      r0_q   <= '0;
      r1_q   <= '0;
      r2_q   <= '0;
      cnt_q  <= '0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        op_q   <= ctl_i.op;
        busy_q <= 1'b1;
        cnt_q  <= '0;
        k_q    <= '0;
        case (ctl_i.op)
          UOP_MUL: begin
            r0_q <= '0;
            r1_q <= x_i;
            r2_q <= y_i;
          end
          UOP_DIV: begin
            r0_q <= x_i;
            r1_q <= y_i;
            r2_q <= '0;
          end
          default: begin
            r0_q <= x_i;
            r1_q <= y_i;
            r2_q <= '0;
          end
        endcase
      end else if (busy_q) begin
        case (op_q)
          UOP_MUL: begin
            if (r2_q[0]) r0_q <= sum[WordW-1:0];
            r1_q  <= r1_q << 1;
            r2_q  <= r2_q >> 1;
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == CntW'(WordW/2 - 1)) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          UOP_DIV: begin
            r2_q  <= borrow ? rem_sh[WordW-1:0] : sum[WordW-1:0];
            r0_q  <= {r0_q[WordW-2:0], ~borrow};
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == CntW'(WordW - 1)) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          default: begin
            // binary gcd: strip common twos, then subtract odd from odd
            if (r0_q == '0) begin
              r0_q   <= r1_q << k_q;
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end else if (r1_q == '0) begin
              r0_q   <= r0_q << k_q;
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end else if (!r0_q[0] && !r1_q[0]) begin
              r0_q <= r0_q >> 1;
              r1_q <= r1_q >> 1;
              k_q  <= k_q + 1'b1;
            end else if (!r0_q[0]) begin
              r0_q <= r0_q >> 1;
            end else if (!r1_q[0]) begin
              r1_q <= r1_q >> 1;
            end else if (!borrow) begin
              r0_q <= sum[WordW-1:0];
            end else begin
              // swap so the larger value sits in r0
              r0_q <= r1_q;
              r1_q <= r0_q;
            end
          end
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = r0_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("unit done without a running operation");

  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("unit still busy after done");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q)
    else $error("unit started while busy");

endmodule

`default_nettype wire

/* src/rational_number_alu.sv */
// ----------------------------------------------------------------------------
// rational_number_alu
// Exact add, subtract, multiply, divide, compare, increment and decrement of
// signed fractions, with gcd reduction and a positive denominator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries a command and two fractions
//   a and b. Output channel out_valid_o/out_ready_i returns one result per
//   item: reduced fraction, compare flags and status.
//   One item is processed at a time; in_ready_o is high only while idle.
//   All work runs on one shared iterative unit: shift-add multiply, restoring
//   divide and binary gcd.
//   Unit steps per command, in order:
//     divide-by-zero          none, straight to the result
//     increment/decrement     reduction only
//     multiply/divide         two multiplies, then reduction
//     compare                 two multiplies, then the comparison
//     add/subtract            denominator gcd, 2 div, 3 mul, reduction
//   Reduction is a gcd and two divides; each gcd runs as long as its operands need.
//   Reset returns the sequencer to idle and drops any pending result.
//   A stalled receiver holds the result on the output; no new item is taken
//   until the result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_number_alu import rna_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [31:0] a_num_i,
  input  wire logic [31:0] a_den_i,
  input  wire logic [31:0] b_num_i,
  input  wire logic [31:0] b_den_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      res_num_o,
  output logic [30:0]      res_den_o,
  output logic             is_less_o,
  output logic             is_equal_o,
  output logic             is_greater_o,
  output logic [1:0]       status_o
);

  localparam logic [WordW-1:0] PosMax = (WordW'(1) << (DATA_WIDTH - 1)) - WordW'(1);
  localparam logic [WordW-1:0] NegMax = WordW'(1) << (DATA_WIDTH - 1);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_GCD0 = 13'b0000000000010,
    S_DIVA = 13'b0000000000100,
    S_DIVB = 13'b0000000001000,
    S_MULD = 13'b0000000010000,
    S_MULA = 13'b0000000100000,
    S_MULB = 13'b0000001000000,
    S_COMB = 13'b0000010000000,
    S_RGCD = 13'b0000100000000,
    S_RDN  = 13'b0001000000000,
    S_RDD  = 13'b0010000000000,
    S_CHK  = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_e;

  state_e           state_q;
  logic             issued_q;
  cmd_e             cmd_q;
  logic             sa_q, sb_q;
  logic [31:0]      a_q, da_q, b_q, db_q;
  logic [31:0]      ma_q, mb_q;
  logic [WordW-1:0] g_q, den_q, ta_q, tb_q, mag_q;
  logic [WordW:0]   num_q;

  logic [31:0]      res_num_q;
  logic [30:0]      res_den_q;
  logic             less_q, equal_q, greater_q;
  status_e          status_q;

  // operand decode at the input
  cmd_e        cmd_in;
  logic [31:0] a_mag, a_dmag, b_mag, b_dmag;
  logic        uses_b, div0;

  assign cmd_in = cmd_e'(command_i);
  assign a_mag  = a_num_i[31] ? (32'd0 - a_num_i) : a_num_i;
  assign a_dmag = a_den_i[31] ? (32'd0 - a_den_i) : a_den_i;
  assign b_mag  = b_num_i[31] ? (32'd0 - b_num_i) : b_num_i;
  assign b_dmag = b_den_i[31] ? (32'd0 - b_den_i) : b_den_i;
  assign uses_b = (command_i <= CMD_CMP);
  assign div0   = (a_dmag == '0) || (uses_b && b_dmag == '0) ||
                  (cmd_in == CMD_DIV && b_mag == '0);

  // shared unit interface
  rna_ctl_t         ctl;
  logic [WordW-1:0] ux, uy, ures;
  logic             udone;
  logic             op_state;

  logic [WordW:0]   va, vb, num_sum;
  logic [WordW-1:0] num_abs;
  logic             neg, ovf;

  assign num_abs = num_q[WordW] ? (WordW'(0) - num_q[WordW-1:0]) : num_q[WordW-1:0];
  assign neg     = num_q[WordW];
  assign va      = sa_q ? ((WordW+1)'(0) - {1'b0, ta_q}) : {1'b0, ta_q};
  assign vb      = sb_q ? ((WordW+1)'(0) - {1'b0, tb_q}) : {1'b0, tb_q};
  assign num_sum = va + vb;
  assign ovf     = (den_q > PosMax) || (neg ? (mag_q > NegMax) : (mag_q > PosMax));

  always_comb begin
    op_state = 1'b1;
    ctl.op   = UOP_MUL;
    ux       = '0;
    uy       = '0;
    unique case (state_q)
      S_GCD0: begin
        ctl.op = UOP_GCD;
        ux     = {32'd0, da_q};
        uy     = {32'd0, db_q};
      end
      S_DIVA: begin
        ctl.op = UOP_DIV;
        ux     = {32'd0, db_q};
        uy     = g_q;
      end
      S_DIVB: begin
        ctl.op = UOP_DIV;
        ux     = {32'd0, da_q};
        uy     = g_q;
      end
      S_MULD: begin
        ux = {32'd0, da_q};
        case (cmd_q)
          CMD_MUL: uy = {32'd0, db_q};
          CMD_DIV: uy = {32'd0, b_q};
          default: uy = {32'd0, ma_q};
        endcase
      end
      S_MULA: begin
        ux = {32'd0, a_q};
        case (cmd_q)
          CMD_MUL:          uy = {32'd0, b_q};
          CMD_DIV, CMD_CMP: uy = {32'd0, db_q};
          default:          uy = {32'd0, ma_q};
        endcase
      end
      S_MULB: begin
        ux = {32'd0, b_q};
        uy = (cmd_q == CMD_CMP) ? {32'd0, da_q} : {32'd0, mb_q};
      end
      S_RGCD: begin
        ctl.op = UOP_GCD;
        ux     = num_abs;
        uy     = den_q;
      end
      S_RDN: begin
        ctl.op = UOP_DIV;
        ux     = num_abs;
        uy     = g_q;
      end
      S_RDD: begin
        ctl.op = UOP_DIV;
        ux     = den_q;
        uy     = g_q;
      end
      default: op_state = 1'b0;
    endcase
    ctl.start = op_state && !issued_q;
  end

  rna_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .x_i    (ux),
    .y_i    (uy),
    .done_o (udone),
    .res_o  (ures)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
    end else begin
      if (ctl.start) issued_q <= 1'b1;
      if (udone)     issued_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (div0) begin
              state_q <= S_OUT;
            end else begin
              case (cmd_in)
                CMD_ADD, CMD_SUB: state_q <= S_GCD0;
                CMD_MUL, CMD_DIV: state_q <= S_MULD;
                CMD_CMP:          state_q <= S_MULA;
                default:          state_q <= S_COMB;
              endcase
            end
          end
        end
        S_GCD0: if (udone) state_q <= S_DIVA;
        S_DIVA: if (udone) state_q <= S_DIVB;
        S_DIVB: if (udone) state_q <= S_MULD;
        S_MULD: if (udone) state_q <= S_MULA;
        S_MULA: begin
          if (udone) begin
            state_q <= (cmd_q == CMD_MUL || cmd_q == CMD_DIV) ? S_COMB : S_MULB;
          end
        end
        S_MULB: if (udone) state_q <= S_COMB;
        S_COMB: state_q <= (cmd_q == CMD_CMP) ? S_OUT : S_RGCD;
        S_RGCD: if (udone) state_q <= S_RDN;
        S_RDN:  if (udone) state_q <= S_RDD;
        S_RDD:  if (udone) state_q <= S_CHK;
        S_CHK:  state_q <= S_OUT;
        S_OUT:  if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        cmd_q     <= cmd_in;
        a_q       <= a_mag;
        da_q      <= a_dmag;
        b_q       <= b_mag;
        db_q      <= b_dmag;
        ta_q      <= {32'd0, a_mag};
        den_q     <= {32'd0, a_dmag};
        res_num_q <= '0;
        res_den_q <= '0;
        less_q    <= 1'b0;
        equal_q   <= 1'b0;
        greater_q <= 1'b0;
        status_q  <= div0 ? ST_DIV0 : ST_OK;
        sa_q      <= a_num_i[31] ^ a_den_i[31];
        sb_q      <= b_num_i[31] ^ b_den_i[31];
        tb_q      <= '0;
        case (cmd_in)
          CMD_SUB: sb_q <= ~(b_num_i[31] ^ b_den_i[31]);
          CMD_MUL, CMD_DIV: sa_q <= a_num_i[31] ^ a_den_i[31] ^ b_num_i[31] ^ b_den_i[31];
          CMD_INC: begin
            sb_q <= 1'b0;
            tb_q <= {32'd0, a_dmag};
          end
          CMD_DEC: begin
            sb_q <= 1'b1;
            tb_q <= {32'd0, a_dmag};
          end
          default: ;
        endcase
      end
      S_GCD0: if (udone) g_q <= ures;
      S_DIVA: if (udone) ma_q <= ures[31:0];
      S_DIVB: if (udone) mb_q <= ures[31:0];
      S_MULD: if (udone) den_q <= ures;
      S_MULA: if (udone) ta_q <= ures;
      S_MULB: if (udone) tb_q <= ures;
      S_COMB: begin
        num_q <= num_sum;
        if (cmd_q == CMD_CMP) begin
          less_q    <= $signed(va) <  $signed(vb);
          equal_q   <= va == vb;
          greater_q <= $signed(va) >  $signed(vb);
        end
      end
      S_RGCD: if (udone) g_q <= ures;
      S_RDN:  if (udone) mag_q <= ures;
      S_RDD:  if (udone) den_q <= ures;
      S_CHK: begin
        if (ovf) begin
          status_q <= ST_OVF;
        end else begin
          res_num_q <= neg ? (32'd0 - mag_q[31:0]) : mag_q[31:0];
          res_den_q <= den_q[30:0];
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign res_num_o    = res_num_q;
  assign res_den_o    = res_den_q;
  assign is_less_o    = less_q;
  assign is_equal_o   = equal_q;
  assign is_greater_o = greater_q;
  assign status_o     = status_q;

  a_done_when_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    udone |-> issued_q)
    else $error("unit result without a launched operation");

  a_err_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |->
      (res_num_o == '0 && res_den_o == '0 && !is_less_o && !is_equal_o && !is_greater_o))
    else $error("error result carries nonzero fields");

  a_cmp_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OK && cmd_q == CMD_CMP) |->
      $onehot({is_less_o, is_equal_o, is_greater_o}))
    else $error("compare result without exactly one flag");

  a_ok_den_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OK && cmd_q != CMD_CMP) |-> res_den_o != '0)
    else $error("fraction result with zero denominator");

endmodule

`default_nettype wire
